[hdl/lcdmt_pkg.sv]
// types and constants shared by the lcd mode timing block
`timescale 1ns / 1ps
package lcdmt_pkg;

  // mode counter thresholds and line numbers
  localparam int unsigned ClkW        = 10;
  localparam int unsigned LineW       = 8;
  localparam logic [ClkW-1:0]  OamTicks    = ClkW'(80);
  localparam logic [ClkW-1:0]  XferTicks   = ClkW'(172);
  localparam logic [ClkW-1:0]  HblankTicks = ClkW'(204);
  localparam logic [ClkW-1:0]  LineTicks   = ClkW'(456);
  localparam logic [LineW-1:0] VblankLine  = LineW'(144);
  localparam logic [LineW-1:0] LastLine    = LineW'(153);

  // lcd mode codes as seen on the status output
  typedef enum logic [1:0] {
    ModeHblank = 2'd0,
    ModeVblank = 2'd1,
    ModeOam    = 2'd2,
    ModeXfer   = 2'd3
  } lcd_mode_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    RegColorMode     = 3'd0,
    RegLineCompare   = 3'd1,
    RegHblankIrqEn   = 3'd2,
    RegVblankStatEn  = 3'd3,
    RegOamIrqEn      = 3'd4,
    RegCompareIrqEn  = 3'd5
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  // one input word
  typedef struct packed {
    logic [7:0] tick_count;
    logic       double_speed;
    logic       hdma_enabled;
  } in_word_t;

  // one result word
  typedef struct packed {
    logic [1:0]       lcd_mode;
    logic [LineW-1:0] current_line;
    logic             coincidence;
    logic             stat_irq;
    logic             vblank_irq;
    logic             render_line;
    logic             hdma_request;
    logic             frame_done;
  } out_word_t;

endpackage

[hdl/lcdmt_if.sv]
// valid/ready channel interfaces for the lcd mode timing block
`timescale 1ns / 1ps

// tick batch input channel
interface lcdmt_in_if import lcdmt_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// timing result channel
interface lcdmt_out_if import lcdmt_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// configuration write channel
interface lcdmt_cfg_if import lcdmt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/lcd_mode_timing_core.sv]
// lcd mode and line timing core
//
// Usage:
//   in_i   takes one word per batch of elapsed clock ticks (tick_count,
//          double_speed, hdma_enabled); in double speed the count is halved.
//   out_o  returns exactly one word per input word: lcd mode, line number,
//          line-compare coincidence, stat and vblank interrupts and the
//          render line, hdma request and frame done pulses.
//   cfg_i  writes the six control registers by index; always ready. Write
//          only while no word is in flight.
// An accepted word is loaded into the input register, the timing update
// runs on it, and the result register takes the outcome once it is free.
// One word is accepted every cycle while out_o does not stall; the mode,
// counter and line registers are updated in that single step, so
// back-to-back words chain without bubbles.
// When out_o stalls, one word waits in the result register and one in the
// input register; in_i drops ready only when both are full.
// Reset puts the block in vertical blank on line 153 with the mode counter
// at zero, clears all control registers and empties both stages.
`timescale 1ns / 1ps
module lcd_mode_timing_core import lcdmt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  lcdmt_in_if.sink           in_i,
  lcdmt_out_if.source        out_o,
  lcdmt_cfg_if.sink          cfg_i
);

  // control registers
  logic             color_mode_q;
  logic [LineW-1:0] line_compare_q;
  logic             hblank_irq_en_q;
  logic             vblank_stat_en_q;
  logic             oam_irq_en_q;
  logic             compare_irq_en_q;

  // timing state
  lcd_mode_e        mode_q, mode_d;
  logic [ClkW-1:0]  mode_clk_q, mode_clk_d;
  logic [LineW-1:0] line_q, line_d;

  // pipeline stages
  logic      s1_valid_q;
  in_word_t  s1_word_q;
  logic      out_valid_q;
  out_word_t out_word_q, out_word_d;
  logic      s1_adv;

  assign cfg_i.ready = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q     <= 1'b0;
      line_compare_q   <= '0;
      hblank_irq_en_q  <= 1'b0;
      vblank_stat_en_q <= 1'b0;
      oam_irq_en_q     <= 1'b0;
      compare_irq_en_q <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegColorMode:    color_mode_q     <= cfg_i.data[0];
        RegLineCompare:  line_compare_q   <= cfg_i.data[LineW-1:0];
        RegHblankIrqEn:  hblank_irq_en_q  <= cfg_i.data[0];
        RegVblankStatEn: vblank_stat_en_q <= cfg_i.data[0];
        RegOamIrqEn:     oam_irq_en_q     <= cfg_i.data[0];
        RegCompareIrqEn: compare_irq_en_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // handshake: stage 1 moves on when the result register frees up
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;

  // timing update for the word in stage 1
  always_comb begin
    logic [7:0]      ticks;
    logic [ClkW-1:0] sum;
    logic [LineW-1:0] nxt_line;
    ticks    = s1_word_q.double_speed ? {1'b0, s1_word_q.tick_count[7:1]}
                                      : s1_word_q.tick_count;
    sum      = mode_clk_q + ClkW'(ticks);
    nxt_line = line_q + LineW'(1);
    mode_d     = mode_q;
    mode_clk_d = sum;
    line_d     = line_q;
    out_word_d = '0;
    unique case (mode_q)
      ModeOam: begin
        if (sum >= OamTicks) begin
          mode_clk_d = '0;
          mode_d     = ModeXfer;
        end
      end
      ModeXfer: begin
        if (sum >= XferTicks) begin
          mode_clk_d             = '0;
          mode_d                 = ModeHblank;
          out_word_d.render_line = 1'b1;
          out_word_d.stat_irq    = hblank_irq_en_q;
        end
      end
      ModeHblank: begin
        if (sum >= HblankTicks) begin
          mode_clk_d = '0;
          line_d     = nxt_line;
          if (nxt_line == VblankLine) begin
            mode_d                = ModeVblank;
            out_word_d.vblank_irq = 1'b1;
            out_word_d.frame_done = 1'b1;
            out_word_d.stat_irq   = vblank_stat_en_q;
          end else begin
            mode_d                  = ModeOam;
            out_word_d.hdma_request = color_mode_q && s1_word_q.hdma_enabled;
            out_word_d.stat_irq     = oam_irq_en_q;
          end
        end
      end
      ModeVblank: begin
        if (sum >= LineTicks) begin
          mode_clk_d = '0;
          line_d     = nxt_line;
          if (line_q >= LastLine) begin
            line_d              = '0;
            mode_d              = ModeOam;
            out_word_d.stat_irq = oam_irq_en_q;
          end
        end
      end
      default: ;
    endcase
    out_word_d.lcd_mode     = mode_d;
    out_word_d.current_line = line_d;
    out_word_d.coincidence  = (line_d == line_compare_q);
    if (out_word_d.coincidence && compare_irq_en_q) begin
      out_word_d.stat_irq = 1'b1;
    end
  end

  // timing state and stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeVblank;
      mode_clk_q  <= '0;
      line_q      <= LastLine;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        mode_q     <= mode_d;
        mode_clk_q <= mode_clk_d;
        line_q     <= line_d;
      end
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_word_q <= in_i.data;
    end
    if (s1_adv) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_word_q;

  // counter always below the longest mode
  a_clk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_clk_q < LineTicks)
    else $error("mode counter out of range");

  // line stays within the frame
  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q <= LastLine)
    else $error("line counter out of range");

  // frame done only when entering vblank on the first vblank line
  a_frame_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_word_q.frame_done) |->
      (out_word_q.lcd_mode == ModeVblank && out_word_q.current_line == VblankLine))
    else $error("frame done outside vblank entry");

  // render pulse only when hblank is entered
  a_render: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_word_q.render_line) |-> out_word_q.lcd_mode == ModeHblank)
    else $error("render pulse outside hblank");

  // state only moves with a word leaving stage 1
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> ($stable(line_q) && $stable(mode_clk_q)))
    else $error("timing state moved without a word");

endmodule
